### hdl/vau_pkg.sv
package vau_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_SUB       = 4'd1;
   localparam logic [3:0] OP_SCALE     = 4'd2;
   localparam logic [3:0] OP_DIVIDE    = 4'd3;
   localparam logic [3:0] OP_LENGTH    = 4'd4;
   localparam logic [3:0] OP_DOT       = 4'd5;
   localparam logic [3:0] OP_NORMALIZE = 4'd6;
   localparam logic [3:0] OP_LERP      = 4'd7;
   localparam logic [3:0] OP_EQUAL     = 4'd8;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] a_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] b_w;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_w;
      logic signed [31:0] scalar_out;
      logic               equal;
      logic [1:0]         status;
   } rsp_type;

   // Control travelling alongside the sqrt and divide pipelines
   typedef struct packed {
      logic [3:0] op;
      rsp_type    pre;
      logic [3:0] neg;
      logic       s_zero;
   } ctl_type;

   localparam int CTL_W = $bits(ctl_type);

   // Saturate a wide signed value to 32 bits; bit 32 of the result flags clipping
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] res;
      if (v > 66'sd2147483647) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

### hdl/vau_front.sv
module vau_front import vau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int DVD_W     = 32 + FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  req_type                    in_req,
   output logic                       out_valid,
   output ctl_type                    out_ctl,
   output logic [63:0]                out_sumsq,
   output logic [3:0][DVD_W-1:0]      out_dvd,
   output logic [31:0]                out_smag
);

   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   // stage 1: products, sums, differences, equality and scalar magnitude
   logic                     v1_ff;
   logic [3:0]               op1_ff;
   logic signed [31:0]       a1_ff   [4];
   logic signed [63:0]       ps1_ff  [4];
   logic signed [64:0]       pl1_ff  [4];
   logic signed [63:0]       pd1_ff  [4];
   logic [62:0]              sq1_ff  [4];
   logic signed [32:0]       add1_ff [4];
   logic signed [32:0]       sub1_ff [4];
   logic                     eq1_ff;
   logic                     sneg1_ff;
   logic [31:0]              smag1_ff;

   logic signed [31:0] a_in [4];
   logic signed [31:0] b_in [4];

   assign a_in[0] = in_req.a_x;
   assign a_in[1] = in_req.a_y;
   assign a_in[2] = in_req.a_z;
   assign a_in[3] = in_req.a_w;
   assign b_in[0] = in_req.b_x;
   assign b_in[1] = in_req.b_y;
   assign b_in[2] = in_req.b_z;
   assign b_in[3] = in_req.b_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_mul
      logic signed [32:0] ae;
      logic signed [32:0] be;
      logic signed [32:0] dba;
      logic signed [64:0] pl_in;
      logic signed [63:0] sq_in;
      assign ae    = {a_in[i][31], a_in[i]};
      assign be    = {b_in[i][31], b_in[i]};
      assign dba   = be - ae;
      assign pl_in = 65'(dba) * 65'(in_req.scalar_in);
      assign sq_in = a_in[i] * a_in[i];
      always_ff @(posedge clock) begin
         a1_ff[i]   <= a_in[i];
         ps1_ff[i]  <= a_in[i] * in_req.scalar_in;
         pl1_ff[i]  <= pl_in;
         pd1_ff[i]  <= a_in[i] * b_in[i];
         sq1_ff[i]  <= sq_in[62:0];
         add1_ff[i] <= ae + be;
         sub1_ff[i] <= ae - be;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= in_req.op;
      eq1_ff   <= (a_in[0] == b_in[0]) && (a_in[1] == b_in[1]) &&
                  (a_in[2] == b_in[2]) && (a_in[3] == b_in[3]);
      sneg1_ff <= in_req.scalar_in[31];
      smag1_ff <= in_req.scalar_in[31] ? 32'(-in_req.scalar_in) : in_req.scalar_in;
   end

   // stage 2: round, sum and saturate
   logic [32:0] add_s [4];
   logic [32:0] sub_s [4];
   logic [32:0] scl_s [4];
   logic [32:0] lrp_s [4];
   logic [32:0] dot_s;
   logic signed [65:0] dot_sum;
   logic [64:0]        sq_sum;
   logic [3:0]         aneg;
   logic [3:0][DVD_W-1:0] dvd_in;

   for (genvar i = 0; i < 4; i++) begin : g_rnd
      logic signed [65:0] scl_r;
      logic signed [65:0] lrp_r;
      logic [31:0]        amag;
      assign scl_r    = (66'(ps1_ff[i]) + HALF) >>> FRAC_BITS;
      assign lrp_r    = ((66'(pl1_ff[i]) + HALF) >>> FRAC_BITS) + 66'(a1_ff[i]);
      assign add_s[i] = sat32(66'(add1_ff[i]));
      assign sub_s[i] = sat32(66'(sub1_ff[i]));
      assign scl_s[i] = sat32(scl_r);
      assign lrp_s[i] = sat32(lrp_r);
      assign aneg[i]  = a1_ff[i][31];
      assign amag     = aneg[i] ? 32'(-a1_ff[i]) : a1_ff[i];
      assign dvd_in[i] = {amag, {FRAC_BITS{1'b0}}};
   end

   assign dot_sum = ((66'(pd1_ff[0]) + 66'(pd1_ff[1]) + 66'(pd1_ff[2]) + 66'(pd1_ff[3]))
                     + HALF) >>> FRAC_BITS;
   assign dot_s   = sat32(dot_sum);
   assign sq_sum  = 65'(sq1_ff[0]) + 65'(sq1_ff[1]) + 65'(sq1_ff[2]) + 65'(sq1_ff[3]);

   ctl_type ctl_in;

   always_comb begin
      logic [32:0] sel [4];
      logic        satf;
      ctl_in        = '0;
      ctl_in.op     = op1_ff;
      ctl_in.s_zero = (smag1_ff == 32'd0);
      ctl_in.neg    = (op1_ff == OP_DIVIDE) ? (aneg ^ {4{sneg1_ff}}) : aneg;
      for (int i = 0; i < 4; i++) begin
         sel[i] = '0;
      end
      satf = 1'b0;
      case (op1_ff)
         OP_ADD:   for (int i = 0; i < 4; i++) sel[i] = add_s[i];
         OP_SUB:   for (int i = 0; i < 4; i++) sel[i] = sub_s[i];
         OP_SCALE: for (int i = 0; i < 4; i++) sel[i] = scl_s[i];
         OP_LERP:  for (int i = 0; i < 4; i++) sel[i] = lrp_s[i];
         OP_DOT: begin
            ctl_in.pre.scalar_out = dot_s[31:0];
            satf                  = dot_s[32];
         end
         OP_EQUAL: ctl_in.pre.equal = eq1_ff;
         default:  ;
      endcase
      ctl_in.pre.r_x = sel[0][31:0];
      ctl_in.pre.r_y = sel[1][31:0];
      ctl_in.pre.r_z = sel[2][31:0];
      ctl_in.pre.r_w = sel[3][31:0];
      satf = satf | sel[0][32] | sel[1][32] | sel[2][32] | sel[3][32];
      ctl_in.pre.status = satf ? ST_SAT : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ctl   <= ctl_in;
      out_sumsq <= sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
      out_dvd   <= dvd_in;
      out_smag  <= smag1_ff;
   end

endmodule

### hdl/vau_sqrt.sv
module vau_sqrt import vau_pkg::*; #(
   parameter int SIDE_W = CTL_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [63:0]       in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);

   // one root bit per stage
   logic              val_ff  [32];
   logic [35:0]       rem_ff  [32];
   logic [31:0]       root_ff [32];
   logic [63:0]       rad_ff  [32];
   logic [SIDE_W-1:0] side_ff [32];

   for (genvar k = 0; k < 32; k++) begin : g_stage
      logic              v_p;
      logic [35:0]       rem_p;
      logic [31:0]       root_p;
      logic [63:0]       rad_p;
      logic [SIDE_W-1:0] side_p;
      logic [35:0]       t;
      logic [35:0]       trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = in_rad;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = val_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign t     = {rem_p[33:0], rad_p[63:62]};
      assign trial = {2'b00, root_p, 2'b01};
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else begin
            val_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= ge ? (t - trial) : t;
         root_ff[k] <= {root_p[30:0], ge};
         rad_ff[k]  <= {rad_p[61:0], 2'b00};
         side_ff[k] <= side_p;
      end
   end

   assign out_valid = val_ff[31];
   assign out_root  = root_ff[31];
   assign out_side  = side_ff[31];

endmodule

### hdl/vau_div.sv
module vau_div import vau_pkg::*; #(
   parameter int DVD_W  = 32 + FRAC_BITS_DEF,
   parameter int SIDE_W = CTL_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [3:0][DVD_W-1:0] in_dvd,
   input  logic [31:0]           in_dvs,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [3:0][DVD_W-1:0] out_quo,
   output logic [SIDE_W-1:0]     out_side
);

   // restoring division, one quotient bit per stage on all four lanes;
   // quotient bits shift into the low end of the dividend register
   logic                  val_ff  [DVD_W];
   logic [3:0][DVD_W-1:0] dvd_ff  [DVD_W];
   logic [3:0][31:0]      rem_ff  [DVD_W];
   logic [31:0]           dvs_ff  [DVD_W];
   logic [SIDE_W-1:0]     side_ff [DVD_W];

   for (genvar k = 0; k < DVD_W; k++) begin : g_stage
      logic                  v_p;
      logic [3:0][DVD_W-1:0] dvd_p;
      logic [3:0][31:0]      rem_p;
      logic [31:0]           dvs_p;
      logic [SIDE_W-1:0]     side_p;
      logic [3:0][DVD_W-1:0] dvd_n;
      logic [3:0][31:0]      rem_n;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign dvd_p  = in_dvd;
         assign rem_p  = '0;
         assign dvs_p  = in_dvs;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = val_ff[k-1];
         assign dvd_p  = dvd_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign dvs_p  = dvs_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic [32:0] t;
         logic [32:0] diff;
         logic        ge;
         assign t          = {rem_p[l], dvd_p[l][DVD_W-1]};
         assign diff       = t - {1'b0, dvs_p};
         assign ge         = (t >= {1'b0, dvs_p});
         assign rem_n[l]   = ge ? diff[31:0] : t[31:0];
         assign dvd_n[l]   = {dvd_p[l][DVD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else begin
            val_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         dvd_ff[k]  <= dvd_n;
         rem_ff[k]  <= rem_n;
         dvs_ff[k]  <= dvs_p;
         side_ff[k] <= side_p;
      end
   end

   assign out_valid = val_ff[DVD_W-1];
   assign out_quo   = dvd_ff[DVD_W-1];
   assign out_side  = side_ff[DVD_W-1];

endmodule

### hdl/vec4_arithmetic_unit.sv
// Four-component Q(32-FRAC_BITS).FRAC_BITS vector unit, fully pipelined.
// A start beat passes the front end, square root, divider and output register in turn.
// Throughput: one beat per cycle; busy stays low, the receiver cannot stall.
// Depth is set by the 32-stage square root and the (32 + FRAC_BITS)-stage divider.
// Reset: synchronous, active high; clears the valid bits, drops beats in flight.
module vec4_arithmetic_unit import vau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int DVD_W   = 32 + FRAC_BITS;
   localparam int SQ_SIDE = 4 * DVD_W + 32 + CTL_W;
   localparam int DV_SIDE = 32 + CTL_W;

   // Every item runs through the whole pipe, whatever its opcode, so results
   // leave in order and no stage ever has to wait. Add, sub, scale, dot, lerp
   // and equal are finished in the front end and simply ride along.
   assign busy = 1'b0;

   // front end: products, then rounding, sums and saturation
   logic                  fe_valid;
   ctl_type               fe_ctl;
   logic [63:0]           fe_sumsq;
   logic [3:0][DVD_W-1:0] fe_dvd;
   logic [31:0]           fe_smag;

   vau_front #(
      .FRAC_BITS (FRAC_BITS),
      .DVD_W     (DVD_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_req    (req_data),
      .out_valid (fe_valid),
      .out_ctl   (fe_ctl),
      .out_sumsq (fe_sumsq),
      .out_dvd   (fe_dvd),
      .out_smag  (fe_smag)
   );

   // square root of the sum of squares; dividends and scalar magnitude ride along
   logic                  sq_valid;
   logic [31:0]           sq_root;
   logic [SQ_SIDE-1:0]    sq_side;
   logic [3:0][DVD_W-1:0] sq_dvd;
   logic [31:0]           sq_smag;
   ctl_type               sq_ctl;

   vau_sqrt #(
      .SIDE_W (SQ_SIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_rad    (fe_sumsq),
      .in_side   ({fe_dvd, fe_smag, fe_ctl}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_dvd, sq_smag, sq_ctl} = sq_side;

   // divide by the scalar for divide, by the length for normalize
   logic                  dv_valid;
   logic [3:0][DVD_W-1:0] dv_quo;
   logic [DV_SIDE-1:0]    dv_side;
   logic [31:0]           dv_root;
   ctl_type               dv_ctl;

   vau_div #(
      .DVD_W  (DVD_W),
      .SIDE_W (DV_SIDE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_dvd    (sq_dvd),
      .in_dvs    ((sq_ctl.op == OP_DIVIDE) ? sq_smag : sq_root),
      .in_side   ({sq_root, sq_ctl}),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign {dv_root, dv_ctl} = dv_side;

   // final stage: apply the quotient sign, saturate, pick the result
   logic [31:0] q_val [4];
   logic [3:0]  q_sat;

   for (genvar l = 0; l < 4; l++) begin : g_sign
      logic big;
      assign big = dv_ctl.neg[l] ? (dv_quo[l] > DVD_W'(33'h0_8000_0000))
                                 : (dv_quo[l] > DVD_W'(33'h0_7FFF_FFFF));
      assign q_sat[l] = big;
      assign q_val[l] = big ? (dv_ctl.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                            : (dv_ctl.neg[l] ? 32'(-dv_quo[l][31:0]) : dv_quo[l][31:0]);
   end

   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = dv_ctl.pre;
      case (dv_ctl.op)
         OP_DIVIDE: begin
            if (dv_ctl.s_zero) begin
               rsp_in.status = ST_DIVZERO;
            end else begin
               rsp_in.r_x    = q_val[0];
               rsp_in.r_y    = q_val[1];
               rsp_in.r_z    = q_val[2];
               rsp_in.r_w    = q_val[3];
               rsp_in.status = (|q_sat) ? ST_SAT : ST_OK;
            end
         end
         OP_NORMALIZE: begin
            if (dv_root != 32'd0) begin
               rsp_in.r_x    = q_val[0];
               rsp_in.r_y    = q_val[1];
               rsp_in.r_z    = q_val[2];
               rsp_in.r_w    = q_val[3];
               rsp_in.status = (|q_sat) ? ST_SAT : ST_OK;
            end
         end
         OP_LENGTH: begin
            // clip lengths above the signed maximum
            rsp_in.scalar_out = dv_root[31] ? 32'h7FFF_FFFF : dv_root;
            rsp_in.status     = dv_root[31] ? ST_SAT : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a division by zero always returns the zero vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_DIVZERO) |->
         (rsp_data.r_x == 32'd0) && (rsp_data.r_y == 32'd0) &&
         (rsp_data.r_z == 32'd0) && (rsp_data.r_w == 32'd0))
      else $error("divide by zero beat carries a non-zero vector");

   // the equality flag never comes with a vector or a scalar
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.equal |->
         (rsp_data.status == ST_OK) && (rsp_data.scalar_out == 32'd0) &&
         (rsp_data.r_x == 32'd0))
      else $error("equal beat carries stray fields");

   // a result can only leave when a quotient left the divider in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(dv_valid))
      else $error("result strobe without a beat from the divider");

endmodule

### sim/tb_top.sv
module tb_top;
   import vau_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam int       FRAC     = FRAC_BITS_DEF;
   localparam wide_type MAX_Q    = 128'sd2147483647;
   localparam wide_type MIN_Q    = -128'sd2147483648;
   localparam wide_type HALF_LSB = 128'sd1 <<< (FRAC - 1);
   // Allow for the whole pipeline to drain, with margin
   localparam int       DRAIN    = 67 + FRAC + 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_results[$];
   bit      failed;

   vec4_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop if the pipeline hangs or beats go missing
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Sign-extend a 32-bit Q value into the wide working type
   function automatic wide_type widen(input logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   // Clip to 32 bits; raise the flag when clipping occurred
   function automatic logic [31:0] clip32(input wide_type v, inout logic flag);
      if (v > MAX_Q) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < MIN_Q) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Round half up at the binary point: add half an LSB, then floor
   function automatic wide_type round_q(input wide_type v);
      return (v + HALF_LSB) >>> FRAC;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitpos;
      root   = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > n) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (n >= root + bitpos) begin
            n    = n - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Euclidean length; the sum of squares is capped at 2^64-1
   function automatic wide_type magnitude(input wide_type v[4]);
      wide_type m;
      wide_type total;
      total = '0;
      for (int i = 0; i < 4; i++) begin
         m     = (v[i] < 0) ? -v[i] : v[i];
         total = total + m * m;
      end
      if (total > wide_type'(64'hFFFF_FFFF_FFFF_FFFF))
         total = wide_type'(64'hFFFF_FFFF_FFFF_FFFF);
      return wide_type'(int_sqrt(total[63:0]));
   endfunction

   function automatic rsp_type predict_vector_result(input req_type q);
      rsp_type     res;
      wide_type    a[4];
      wide_type    b[4];
      wide_type    s;
      wide_type    len;
      wide_type    acc;
      logic [31:0] vec[4];
      logic        clipped;
      a   = '{widen(q.a_x), widen(q.a_y), widen(q.a_z), widen(q.a_w)};
      b   = '{widen(q.b_x), widen(q.b_y), widen(q.b_z), widen(q.b_w)};
      s   = widen(q.scalar_in);
      vec = '{default: '0};
      res = '0;
      clipped = 1'b0;
      case (q.op)
         OP_ADD: begin
            for (int i = 0; i < 4; i++) vec[i] = clip32(a[i] + b[i], clipped);
         end
         OP_SUB: begin
            for (int i = 0; i < 4; i++) vec[i] = clip32(a[i] - b[i], clipped);
         end
         OP_SCALE: begin
            for (int i = 0; i < 4; i++) vec[i] = clip32(round_q(a[i] * s), clipped);
         end
         OP_DIVIDE: begin
            if (s == 0) begin
               res.status = ST_DIVZERO;
            end else begin
               for (int i = 0; i < 4; i++) vec[i] = clip32((a[i] <<< FRAC) / s, clipped);
            end
         end
         OP_LENGTH: begin
            res.scalar_out = clip32(magnitude(a), clipped);
         end
         OP_DOT: begin
            acc = '0;
            for (int i = 0; i < 4; i++) acc = acc + a[i] * b[i];
            res.scalar_out = clip32(round_q(acc), clipped);
         end
         OP_NORMALIZE: begin
            len = magnitude(a);
            if (len != 0) begin
               for (int i = 0; i < 4; i++) vec[i] = clip32((a[i] <<< FRAC) / len, clipped);
            end
         end
         OP_LERP: begin
            for (int i = 0; i < 4; i++)
               vec[i] = clip32(a[i] + round_q((b[i] - a[i]) * s), clipped);
         end
         OP_EQUAL: begin
            res.equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
         end
         default: ;
      endcase
      res.r_x = vec[0];
      res.r_y = vec[1];
      res.r_z = vec[2];
      res.r_w = vec[3];
      if (clipped && res.status == ST_OK) res.status = ST_SAT;
      return res;
   endfunction

   // Present one beat, after a random gap when allowed; hold until the unit takes it
   task automatic send_beat(input req_type q, input bit allow_gap = 1'b1);
      int gap;
      gap = allow_gap ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_vector_result(q));
   endtask

   // Skewed operand: extremes, small Q values, or full-range noise
   function automatic logic [31:0] pick_q();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         1: return 32'($signed($urandom_range(0, 64)) - 32) <<< FRAC;
         2: return 32'($signed($urandom_range(0, 8191)) - 4096);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_req(input logic [3:0] op, input logic [31:0] ax,
                                        input logic [31:0] ay, input logic [31:0] az,
                                        input logic [31:0] aw, input logic [31:0] bx,
                                        input logic [31:0] by, input logic [31:0] bz,
                                        input logic [31:0] bw, input logic [31:0] sc);
      req_type q;
      q.op = op;
      q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
      q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
      q.scalar_in = sc;
      return q;
   endfunction

   // Extremes, every opcode and the corner cases, back to back and with gaps
   task automatic test_directed();
      localparam logic [31:0] MX = 32'h7FFF_FFFF;
      localparam logic [31:0] MN = 32'h8000_0000;
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] NEG1 = 32'hFFFF_0000;
      send_beat(make_req(OP_ADD, MX, MN, ONE, 0, MX, MN, NEG1, 0, 0));
      send_beat(make_req(OP_SUB, MN, MX, 5, 0, MX, MN, 3, 0, 0), 1'b0);
      send_beat(make_req(OP_SCALE, MX, MN, ONE, 3, 0, 0, 0, 0, NEG1), 1'b0);
      send_beat(make_req(OP_SCALE, MX, MN, 1, 32'h8000, 0, 0, 0, 0, MX));
      send_beat(make_req(OP_SCALE, 32'h0000_8000, 32'hFFFF_8000, 1, 0, 0, 0, 0, 0, 32'h8000));
      send_beat(make_req(OP_DIVIDE, ONE, MX, MN, 7, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_DIVIDE, MX, MN, NEG1, 7, 0, 0, 0, 0, 1), 1'b0);
      send_beat(make_req(OP_DIVIDE, MN, ONE, 3, MX, 0, 0, 0, 0, 32'h0003_0000));
      send_beat(make_req(OP_LENGTH, MN, MN, MN, MN, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_LENGTH, MX, MX, MX, MX, 0, 0, 0, 0, 0), 1'b0);
      send_beat(make_req(OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_DOT, MX, MN, MX, MN, MX, MN, MX, MN, 0));
      send_beat(make_req(OP_DOT, ONE, NEG1, 1, 32'h8000, ONE, ONE, 32'h8000, 1, 0), 1'b0);
      send_beat(make_req(OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_NORMALIZE, MN, MN, MN, MN, 0, 0, 0, 0, 0), 1'b0);
      send_beat(make_req(OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_NORMALIZE, MX, NEG1, 3, MN, 0, 0, 0, 0, 0));
      send_beat(make_req(OP_LERP, MN, MX, 0, ONE, MX, MN, ONE, 0, MX));
      send_beat(make_req(OP_LERP, 0, ONE, NEG1, 5, ONE, 0, ONE, 6, 32'h8000), 1'b0);
      send_beat(make_req(OP_EQUAL, MX, MN, 1, 0, MX, MN, 1, 0, 0));
      send_beat(make_req(OP_EQUAL, MX, MN, 1, 0, MX, MN, 1, 1, 0), 1'b0);
      send_beat(make_req(4'd9, MX, MX, MX, MX, MX, MX, MX, MX, MX));
      send_beat(make_req(4'd15, MN, MN, MN, MN, MN, MN, MN, MN, MN), 1'b0);
   endtask

   // Random mix; bias towards equal pairs, zero divisors and zero vectors
   task automatic test_random(input int count);
      req_type q;
      for (int n = 0; n < count; n++) begin
         q.op = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
         q.a_x = pick_q(); q.a_y = pick_q(); q.a_z = pick_q(); q.a_w = pick_q();
         q.b_x = pick_q(); q.b_y = pick_q(); q.b_z = pick_q(); q.b_w = pick_q();
         q.scalar_in = pick_q();
         case ($urandom_range(0, 9))
            0: {q.b_x, q.b_y, q.b_z, q.b_w} = {q.a_x, q.a_y, q.a_z, q.a_w};
            1: q.scalar_in = '0;
            2: {q.a_x, q.a_y, q.a_z, q.a_w} = '0;
            default: ;
         endcase
         // Stretches with no gaps at all
         send_beat(q, (n % 100) >= 40);
      end
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // Compare each result beat with the oldest outstanding prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            report_field("r_x", want.r_x, rsp_data.r_x);
            report_field("r_y", want.r_y, rsp_data.r_y);
            report_field("r_z", want.r_z, rsp_data.r_z);
            report_field("r_w", want.r_w, rsp_data.r_w);
            report_field("scalar_out", want.scalar_out, rsp_data.scalar_out);
            report_field("equal", 32'(want.equal), 32'(rsp_data.equal));
            report_field("status", 32'(want.status), 32'(rsp_data.status));
         end
      end
   end

   initial begin
      failed   = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(750);
      start <= 1'b0;

      // Drain the pipeline, then idle a little longer for stray beats
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_sqrt.sv
hdl/vau_div.sv
hdl/vec4_arithmetic_unit.sv
sim/tb_top.sv
